// ----- design/ipl_pkg.sv -----
`default_nettype none

package ipl_pkg;

  // Fixed index geometry: one group per first octet
  localparam int unsigned OCTET_GROUPS = 256;
  localparam int unsigned OCTET_W      = 8;
  localparam int unsigned OCTET_MASK   = 255;
  localparam logic [OCTET_W:0] NO_OCTET = 9'd256;

  // Payload widths
  localparam int unsigned IP_W         = 32;
  localparam int unsigned TAG_W        = 16;
  localparam int unsigned ENTRY_IDX_W  = 10;

  // Parameter defaults
  localparam int unsigned DEF_TABLE_DEPTH = 1024;
  localparam int unsigned DEF_REGION_BITS = 16;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  // Commands to the group index
  typedef struct packed {
    logic               load;
    logic               query;
    logic               clear;
    logic [OCTET_W-1:0] octet;
  } grp_cmd_t;

  // Commands to the entry store
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } ent_ctl_t;

endpackage

`default_nettype wire

// ----- design/ipl_if.sv -----
`default_nettype none

// Request channel: one beat per load, query or clear
interface ipl_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] ip_value;
  logic [15:0] region_tag;

  modport source (output valid, operation, ip_value, region_tag, input ready);
  modport sink   (input valid, operation, ip_value, region_tag, output ready);
endinterface

// Result channel: one beat per request
interface ipl_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [9:0]  entry_index;
  logic [15:0] region_out;

  modport source (output valid, found, entry_index, region_out, input ready);
  modport sink   (input valid, found, entry_index, region_out, output ready);
endinterface

`default_nettype wire

// ----- design/ipl_entry_store.sv -----
`default_nettype none

module ipl_entry_store
  import ipl_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int unsigned REGION_BITS = DEF_REGION_BITS,
  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  wire logic                   clk_i,
  input  wire ent_ctl_t               ctl_i,
  input  wire logic [IDX_W-1:0]       addr_i,
  input  wire logic [IP_W-1:0]        wr_end_i,
  input  wire logic [REGION_BITS-1:0] wr_region_i,
  output logic [IP_W-1:0]             rd_end_o,
  output logic [REGION_BITS-1:0]      rd_region_o
);

  localparam int unsigned WORD_W = IP_W + REGION_BITS;

  logic [WORD_W-1:0] mem_q [TABLE_DEPTH];
  logic [WORD_W-1:0] rd_word_q;

  // Write one range per load
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[addr_i] <= {wr_end_i, wr_region_i};
    end
  end

  // Registered read for search probes
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rd_word_q <= mem_q[addr_i];
    end
  end

  assign rd_end_o    = rd_word_q[WORD_W-1:REGION_BITS];
  assign rd_region_o = rd_word_q[REGION_BITS-1:0];

endmodule

`default_nettype wire

// ----- design/ipl_group_index.sv -----
`default_nettype none

module ipl_group_index
  import ipl_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH,
  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire grp_cmd_t         cmd_i,
  input  wire logic [IDX_W-1:0] slot_i,
  output logic                  present_o,
  output logic [IDX_W-1:0]      first_o,
  output logic [IDX_W-1:0]      last_o
);

  logic [2*IDX_W-1:0]      span_mem_q [OCTET_GROUPS];
  logic [2*IDX_W-1:0]      span_rd_q;
  logic [OCTET_GROUPS-1:0] present_q;
  logic                    hit_q;
  logic [OCTET_W:0]        prev_octet_q;
  logic [IDX_W-1:0]        open_first_q;
  logic                    same_group;

  // A load extends the open group only when its octet repeats the last one
  assign same_group = (prev_octet_q == {1'b0, cmd_i.octet}) && present_q[cmd_i.octet];

  // Span memory: write on load, registered read on query
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      span_mem_q[cmd_i.octet] <= same_group ? {open_first_q, slot_i} : {slot_i, slot_i};
    end
    if (cmd_i.query) begin
      span_rd_q <= span_mem_q[cmd_i.octet];
    end
  end

  // Presence bits, open group tracking, presence read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q    <= '0;
      hit_q        <= 1'b0;
      prev_octet_q <= NO_OCTET;
      open_first_q <= '0;
    end else begin
      if (cmd_i.clear) begin
        present_q    <= '0;
        prev_octet_q <= NO_OCTET;
      end else if (cmd_i.load) begin
        present_q[cmd_i.octet] <= 1'b1;
        if (!same_group) begin
          prev_octet_q <= {1'b0, cmd_i.octet};
          open_first_q <= slot_i;
        end
      end
      if (cmd_i.query) begin
        hit_q <= present_q[cmd_i.octet];
      end
    end
  end

  assign present_o = hit_q;
  assign first_o   = span_rd_q[2*IDX_W-1:IDX_W];
  assign last_o    = span_rd_q[IDX_W-1:0];

endmodule

`default_nettype wire

// ----- design/ip_range_lookup_top.sv -----
`default_nettype none

// IPv4 range lookup. Loads append (end address, region) entries to a table of
// TABLE_DEPTH slots in ascending order and keep a per-first-octet span index;
// queries binary-search the span of their first octet for the lowest entry
// whose end address is at or above the key. Every request beat gets exactly
// one result beat. Load, clear and unused codes answer from the idle state
// with no search. A query first takes its octet span in the span state; each
// probe then reads the entry memory through its single port in the probe
// state and compares on the next cycle in the compare state, a last probe state
// finds the window empty and the done state stages the result. A span of N
// entries needs at most ceil(log2(N+1)) probes; a query whose octet has no
// group skips the probes and goes to the done state. Presence bits for the 256
// groups sit in flip-flops, so reset and clear need no sweep of the memories.
// A new request is taken while a finished result waits in the output register;
// a second finished result parks in the search engine, and requests stall
// until the waiting output beat is taken.
module ip_range_lookup_top
  import ipl_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int unsigned REGION_BITS = DEF_REGION_BITS
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ipl_in_if.sink    req_i,
  ipl_out_if.source rsp_o
);

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPAN,
    ST_PROBE,
    ST_CMP,
    ST_DONE
  } state_e;

  state_e                 state_q, state_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [IP_W-1:0]        key_q, key_d;
  logic [CNT_W-1:0]       lo_q, lo_d;
  logic [CNT_W-1:0]       hp_q, hp_d;
  logic [IDX_W-1:0]       mid_q, mid_d;
  logic                   best_found_q, best_found_d;
  logic [IDX_W-1:0]       best_idx_q, best_idx_d;
  logic [REGION_BITS-1:0] best_region_q, best_region_d;
  logic                   out_valid_q, out_valid_d;
  logic                   out_found_q, out_found_d;
  logic [ENTRY_IDX_W-1:0] out_idx_q, out_idx_d;
  logic [TAG_W-1:0]       out_region_q, out_region_d;

  logic                   in_ready;
  logic                   accept;
  logic                   out_free;
  logic                   full;
  logic [IDX_W-1:0]       slot;
  logic [IDX_W-1:0]       mid_w;
  logic [REGION_BITS-1:0] tag_w;
  logic [OCTET_W-1:0]     octet_w;
  grp_cmd_t               grp_cmd;
  ent_ctl_t               ent_ctl;
  logic [IDX_W-1:0]       ent_addr;
  logic                   grp_present;
  logic [IDX_W-1:0]       grp_first;
  logic [IDX_W-1:0]       grp_last;
  logic [IP_W-1:0]        ent_end;
  logic [REGION_BITS-1:0] ent_region;

  ipl_group_index #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_group_index (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (grp_cmd),
    .slot_i   (slot),
    .present_o(grp_present),
    .first_o  (grp_first),
    .last_o   (grp_last)
  );

  ipl_entry_store #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .REGION_BITS(REGION_BITS)
  ) u_entry_store (
    .clk_i      (clk_i),
    .ctl_i      (ent_ctl),
    .addr_i     (ent_addr),
    .wr_end_i   (req_i.ip_value),
    .wr_region_i(tag_w),
    .rd_end_o   (ent_end),
    .rd_region_o(ent_region)
  );

  // Handshake
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign in_ready    = (state_q == ST_IDLE);
  assign accept      = req_i.valid && in_ready;
  assign req_i.ready = in_ready;

  assign full    = (count_q == CNT_W'(TABLE_DEPTH));
  assign slot    = count_q[IDX_W-1:0];
  assign tag_w   = REGION_BITS'(req_i.region_tag);
  assign octet_w = req_i.ip_value[IP_W-1 -: OCTET_W];

  // Midpoint of the closed span [lo, hp-1]
  assign mid_w = IDX_W'(lo_q + ((hp_q - lo_q - 1'b1) >> 1));

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    key_d         = key_q;
    lo_d          = lo_q;
    hp_d          = hp_q;
    mid_d         = mid_q;
    best_found_d  = best_found_q;
    best_idx_d    = best_idx_q;
    best_region_d = best_region_q;
    out_valid_d   = out_valid_q && !rsp_o.ready;
    out_found_d   = out_found_q;
    out_idx_d     = out_idx_q;
    out_region_d  = out_region_q;
    grp_cmd       = '0;
    grp_cmd.octet = octet_w;
    ent_ctl       = '0;
    ent_addr      = mid_w;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          // Default answer: all zero
          best_found_d  = 1'b0;
          best_idx_d    = '0;
          best_region_d = '0;
          case (op_e'(req_i.operation))
            OP_LOAD: begin
              if (!full) begin
                ent_ctl.wr_en = 1'b1;
                ent_addr      = slot;
                grp_cmd.load  = 1'b1;
                count_d       = count_q + 1'b1;
                best_found_d  = 1'b1;
                best_idx_d    = slot;
                best_region_d = tag_w;
              end
            end
            OP_QUERY: begin
              grp_cmd.query = 1'b1;
              key_d         = req_i.ip_value;
              state_d       = ST_SPAN;
            end
            OP_CLEAR: begin
              grp_cmd.clear = 1'b1;
              count_d       = '0;
            end
            default: begin
            end
          endcase
          // Answer at once, or park the answer while the output beat waits
          if (req_i.operation != OP_QUERY) begin
            if (out_free) begin
              out_valid_d  = 1'b1;
              out_found_d  = best_found_d;
              out_idx_d    = ENTRY_IDX_W'(best_idx_d);
              out_region_d = TAG_W'(best_region_d);
            end else begin
              state_d = ST_DONE;
            end
          end
        end
      end
      ST_SPAN: begin
        // Open the search window on the group span
        best_found_d = 1'b0;
        lo_d         = CNT_W'(grp_first);
        hp_d         = CNT_W'(grp_last) + 1'b1;
        state_d      = grp_present ? ST_PROBE : ST_DONE;
      end
      ST_PROBE: begin
        if (lo_q < hp_q) begin
          ent_ctl.rd_en = 1'b1;
          mid_d         = mid_w;
          state_d       = ST_CMP;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_CMP: begin
        // Narrow toward the lowest covering end
        if (ent_end >= key_q) begin
          best_found_d  = 1'b1;
          best_idx_d    = mid_q;
          best_region_d = ent_region;
          hp_d          = CNT_W'(mid_q);
        end else begin
          lo_d = CNT_W'(mid_q) + 1'b1;
        end
        state_d = ST_PROBE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_found_d  = best_found_q;
          out_idx_d    = best_found_q ? ENTRY_IDX_W'(best_idx_q) : '0;
          out_region_d = best_found_q ? TAG_W'(best_region_q) : '0;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold state, search window and the output beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      count_q       <= '0;
      key_q         <= '0;
      lo_q          <= '0;
      hp_q          <= '0;
      mid_q         <= '0;
      best_found_q  <= 1'b0;
      best_idx_q    <= '0;
      best_region_q <= '0;
      out_valid_q   <= 1'b0;
      out_found_q   <= 1'b0;
      out_idx_q     <= '0;
      out_region_q  <= '0;
    end else begin
      state_q       <= state_d;
      count_q       <= count_d;
      key_q         <= key_d;
      lo_q          <= lo_d;
      hp_q          <= hp_d;
      mid_q         <= mid_d;
      best_found_q  <= best_found_d;
      best_idx_q    <= best_idx_d;
      best_region_q <= best_region_d;
      out_valid_q   <= out_valid_d;
      out_found_q   <= out_found_d;
      out_idx_q     <= out_idx_d;
      out_region_q  <= out_region_d;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.found       = out_found_q;
  assign rsp_o.entry_index = out_idx_q;
  assign rsp_o.region_out  = out_region_q;

  // Fill count never passes the table depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // Each probe lies inside the current window
  a_probe_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CMP |-> (CNT_W'(mid_q) >= lo_q) && (CNT_W'(mid_q) < hp_q))
    else $error("probe outside search window");

  // A hit always names a filled slot
  a_hit_filled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) && best_found_q |-> CNT_W'(best_idx_q) < count_q)
    else $error("search hit beyond filled entries");

  // An accepted load into a free slot advances the fill count by one
  a_load_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (req_i.operation == OP_LOAD) && !full
    |=> count_q == CNT_W'($past(count_q) + 1'b1))
    else $error("load did not advance entry count");

  // A query holds off new requests until its result is staged
  a_query_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (req_i.operation == OP_QUERY) |=> !req_i.ready)
    else $error("query overlapped with another request");

endmodule

`default_nettype wire

// ----- tb/tb_ip_range_lookup_top.sv -----
`timescale 1ns / 100ps

module tb_ip_range_lookup_top;
  import ipl_pkg::*;

  localparam int unsigned TABLE_DEPTH  = DEF_TABLE_DEPTH;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned TAIL_CYCLES  = 40;
  localparam int unsigned REPORT_LIMIT = 40;
  localparam int unsigned LONG_HOLD    = 400;

  typedef struct packed {
    logic                   found;
    logic [ENTRY_IDX_W-1:0] entry_index;
    logic [TAG_W-1:0]       region_out;
  } lookup_rsp_t;

  logic clk_i;
  logic rst_ni;

  ipl_in_if  req_if ();
  ipl_out_if rsp_if ();

  ip_range_lookup_top dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // Shadow copy of the range table and the first-octet span index
  logic [IP_W-1:0]  shadow_end    [TABLE_DEPTH];
  logic [TAG_W-1:0] shadow_region [TABLE_DEPTH];
  int unsigned      span_first    [OCTET_GROUPS];
  int unsigned      span_last     [OCTET_GROUPS];
  bit               span_present  [OCTET_GROUPS];
  int unsigned      shadow_count;
  int unsigned      open_octet;

  lookup_rsp_t pending_lookups_q[$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_req_seq;
  int unsigned beats_sent;
  int unsigned err_count;
  int unsigned cycle_count;

  // Empty the shadow table the way a clear beat does
  function automatic void clear_shadow();
    foreach (span_present[g]) span_present[g] = 1'b0;
    shadow_count = 0;
    open_octet   = int'(NO_OCTET);
  endfunction

  // Apply one request to the shadow table and return the answer it earns
  function automatic lookup_rsp_t predict_lookup(input logic [1:0]      op,
                                                 input logic [IP_W-1:0]  ip,
                                                 input logic [TAG_W-1:0] tag);
    lookup_rsp_t rsp;
    int unsigned octet;
    int          lo;
    int          hi;
    int          mid;
    int          best;
    rsp   = '0;
    octet = int'(ip[31:24]);
    best  = -1;
    case (op)
      OP_LOAD: begin
        if (shadow_count < TABLE_DEPTH) begin
          shadow_end[shadow_count]    = ip;
          shadow_region[shadow_count] = tag;
          // Extend the open group, or restart the span at the new slot
          if (octet == open_octet && span_present[octet]) begin
            span_last[octet] = shadow_count;
          end else begin
            span_first[octet]   = shadow_count;
            span_last[octet]    = shadow_count;
            span_present[octet] = 1'b1;
            open_octet          = octet;
          end
          rsp.found       = 1'b1;
          rsp.entry_index = ENTRY_IDX_W'(shadow_count);
          rsp.region_out  = tag;
          shadow_count++;
        end
      end
      OP_QUERY: begin
        if (span_present[octet]) begin
          lo = span_first[octet];
          hi = span_last[octet];
          if (hi >= int'(shadow_count)) hi = int'(shadow_count) - 1;
          // Search for the lowest entry whose end covers the key
          while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (shadow_end[mid] >= ip) begin
              best = mid;
              hi   = mid - 1;
            end else begin
              lo = mid + 1;
            end
          end
          if (best >= 0) begin
            rsp.found       = 1'b1;
            rsp.entry_index = ENTRY_IDX_W'(best);
            rsp.region_out  = shadow_region[best];
          end
        end
      end
      OP_CLEAR: begin
        clear_shadow();
      end
      default: begin
      end
    endcase
    return rsp;
  endfunction

  task automatic report_mismatch(input string field, input int unsigned exp_val,
                                 input int unsigned act_val);
    err_count++;
    if (err_count <= REPORT_LIMIT)
      $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, field, exp_val, act_val);
  endtask

  // Clock
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t ns: timeout with %0d results outstanding", $time, pending_lookups_q.size());
      $display("[ip_range_lookup_top] ERROR");
      $finish;
    end
  end

  // Check each result beat, then predict each accepted request beat
  always @(posedge clk_i) begin
    lookup_rsp_t exp_rsp;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (pending_lookups_q.size() == 0) begin
          report_mismatch("unexpected result", 0,
                          {rsp_if.found, rsp_if.entry_index, rsp_if.region_out});
        end else begin
          exp_rsp = pending_lookups_q.pop_front();
          if (rsp_if.found !== exp_rsp.found)
            report_mismatch("found", exp_rsp.found, rsp_if.found);
          if (rsp_if.entry_index !== exp_rsp.entry_index)
            report_mismatch("entry_index", exp_rsp.entry_index, rsp_if.entry_index);
          if (rsp_if.region_out !== exp_rsp.region_out)
            report_mismatch("region_out", exp_rsp.region_out, rsp_if.region_out);
        end
      end
      if (req_if.valid && req_if.ready)
        pending_lookups_q.insert(pending_lookups_q.size(),
                                 predict_lookup(req_if.operation, req_if.ip_value,
                                                req_if.region_tag));
    end
  end

  // Result receiver: random stalls, plus long hold-offs on request
  initial begin : result_receiver
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left    = 0;
    hold_seen    = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req_seq != hold_seen) begin
        hold_left = LONG_HOLD;
        hold_seen = hold_req_seq;
      end
      if (!rst_ni) begin
        rsp_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one request beat, with a random gap ahead of it, and hold it until taken
  task automatic send_beat(input logic [1:0] op, input logic [IP_W-1:0] ip,
                           input logic [TAG_W-1:0] tag);
    if ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    req_if.valid      <= 1'b1;
    req_if.operation  <= op;
    req_if.ip_value   <= ip;
    req_if.region_tag <= tag;
    do @(posedge clk_i); while (!req_if.ready);
    beats_sent++;
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic wait_results_drained();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_lookups_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    // Empty table and unused code
    send_beat(OP_QUERY,  32'h0A00_0001, 16'hFFFF);
    send_beat(OP_UNUSED, 32'hFFFF_FFFF, 16'hFFFF);
    send_beat(OP_CLEAR,  32'h0000_0000, 16'h0000);
    // Extreme ends and tags
    send_beat(OP_LOAD, 32'h0000_0000, 16'h0000);
    send_beat(OP_LOAD, 32'h00FF_FFFF, 16'hFFFF);
    send_beat(OP_LOAD, 32'h0100_0000, 16'h1234);
    send_beat(OP_LOAD, 32'h80FF_0000, 16'hA5A5);
    send_beat(OP_LOAD, 32'h80FF_FFFF, 16'h5A5A);
    send_beat(OP_LOAD, 32'hFFFF_FFFF, 16'hFFFF);
    send_beat(OP_QUERY, 32'h0000_0000, 16'hFFFF);
    send_beat(OP_QUERY, 32'h0080_0000, 16'h0000);
    send_beat(OP_QUERY, 32'h00FF_FFFF, 16'h0000);
    send_beat(OP_QUERY, 32'h0100_0001, 16'h0000);
    send_beat(OP_QUERY, 32'h8000_0000, 16'h0000);
    send_beat(OP_QUERY, 32'h80FF_0001, 16'h0000);
    send_beat(OP_QUERY, 32'hFFFF_FFFF, 16'h0000);
    send_beat(OP_QUERY, 32'h7F00_0000, 16'h0000);
    // Revisit an octet: the earlier span is dropped
    send_beat(OP_LOAD,  32'h2000_0010, 16'h0001);
    send_beat(OP_LOAD,  32'h2100_0010, 16'h0002);
    send_beat(OP_LOAD,  32'h2000_0020, 16'h0003);
    send_beat(OP_QUERY, 32'h2000_0005, 16'h0000);
    send_beat(OP_QUERY, 32'h2100_0011, 16'h0000);
    send_beat(OP_UNUSED, 32'h2000_0005, 16'h0000);
    send_beat(OP_CLEAR, 32'hFFFF_FFFF, 16'hFFFF);
    send_beat(OP_QUERY, 32'h0000_0000, 16'h0000);
    wait_results_drained();
  endtask

  task automatic test_table_full();
    send_beat(OP_CLEAR, 32'h0, 16'h0);
    // One deep span, then a short one, until every slot is taken
    for (int i = 0; i < int'(TABLE_DEPTH); i++) begin
      if (i < 1000) send_beat(OP_LOAD, {8'h7F, 24'(i * 16)}, 16'($urandom));
      else          send_beat(OP_LOAD, {8'hC3, 24'(i * 16)}, 16'($urandom));
    end
    send_beat(OP_LOAD, 32'hC3FF_FFFF, 16'hFFFF);
    send_beat(OP_LOAD, 32'hD000_0000, 16'h1111);
    send_beat(OP_QUERY, 32'h7F00_0000, 16'h0000);
    send_beat(OP_QUERY, 32'h7F00_3E7F, 16'h0000);
    send_beat(OP_QUERY, 32'h7F00_3E81, 16'h0000);
    send_beat(OP_QUERY, 32'h7FFF_FFFF, 16'h0000);
    send_beat(OP_QUERY, 32'hC300_3E80, 16'h0000);
    send_beat(OP_QUERY, 32'hD000_0000, 16'h0000);
    repeat (12) send_beat(OP_QUERY, {8'h7F, 24'($urandom_range(16100))}, 16'($urandom));
    send_beat(OP_CLEAR, 32'h0, 16'h0);
    send_beat(OP_QUERY, 32'h7F00_0000, 16'h0000);
    wait_results_drained();
  endtask

  task automatic test_backpressure();
    send_beat(OP_CLEAR, 32'h0, 16'h0);
    for (int i = 0; i < 20; i++) send_beat(OP_LOAD, {8'h42, 24'(i * 1000)}, 16'(i + 1));
    wait_results_drained();
    // Hold the result side while requests keep coming
    hold_req_seq++;
    repeat (40) send_beat(OP_QUERY, {8'h42, 24'($urandom_range(21000))}, 16'($urandom));
    wait_results_drained();
    // Sender paused until empty; resume with a short burst
    repeat (10) send_beat(OP_QUERY, {8'h42, 24'($urandom_range(21000))}, 16'($urandom));
    wait_results_drained();
  endtask

  task automatic test_random_tables(input int unsigned item_budget);
    logic [IP_W-1:0] ends_q[$];
    logic [7:0]      octet_pool[4];
    logic [IP_W-1:0] val;
    int unsigned     start;
    int unsigned     n_ent;
    int unsigned     n_ask;
    int unsigned     pos;
    int unsigned     pick;
    start = beats_sent;
    while (beats_sent - start < item_budget) begin
      // Build an ascending table over a few first octets
      ends_q.delete();
      foreach (octet_pool[p]) octet_pool[p] = 8'($urandom);
      n_ent = ($urandom_range(15) == 0) ? $urandom_range(300, 64) : $urandom_range(24, 1);
      for (int k = 0; k < int'(n_ent); k++) begin
        val = {octet_pool[$urandom_range(3)], 24'($urandom)};
        if ($urandom_range(9) == 0 && ends_q.size() != 0)
          val = ends_q[$urandom_range(ends_q.size() - 1)];
        pos = 0;
        while (pos < ends_q.size() && ends_q[pos] <= val) pos++;
        ends_q.insert(pos, val);
      end
      send_beat(OP_CLEAR, $urandom, 16'($urandom));
      foreach (ends_q[k]) send_beat(OP_LOAD, ends_q[k], 16'($urandom));
      // Query around the stored ends, with some noise mixed in
      n_ask = $urandom_range((2 * n_ent + 4 > 40) ? 40 : 2 * n_ent + 4, 4);
      repeat (n_ask) begin
        pick = $urandom_range(ends_q.size() - 1);
        case ($urandom_range(9))
          0, 1: send_beat(OP_QUERY, ends_q[pick], 16'($urandom));
          2:    send_beat(OP_QUERY, ends_q[pick] + 32'd1, 16'($urandom));
          3:    send_beat(OP_QUERY, ends_q[pick] - 32'd1, 16'($urandom));
          4, 5: send_beat(OP_QUERY, {octet_pool[$urandom_range(3)], 24'($urandom)},
                          16'($urandom));
          6:    send_beat(OP_QUERY, $urandom, 16'($urandom));
          7:    send_beat(OP_QUERY, {octet_pool[$urandom_range(3)],
                                     ($urandom_range(1) != 0) ? 24'hFF_FFFF : 24'h0},
                          16'($urandom));
          8:    send_beat(($urandom_range(1) != 0) ? OP_LOAD : OP_UNUSED,
                          {octet_pool[$urandom_range(3)], 24'($urandom)}, 16'($urandom));
          default: begin
            if ($urandom_range(3) == 0) send_beat(OP_CLEAR, $urandom, 16'($urandom));
            else send_beat(2'($urandom_range(3)), $urandom, 16'($urandom));
          end
        endcase
      end
    end
    wait_results_drained();
  endtask

  initial begin
    rst_ni            = 1'b0;
    req_if.valid      = 1'b0;
    req_if.operation  = OP_LOAD;
    req_if.ip_value   = '0;
    req_if.region_tag = '0;
    hold_req_seq      = 0;
    beats_sent        = 0;
    err_count         = 0;
    cycle_count       = 0;
    clear_shadow();

    // Reset once
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 38;
    recv_idle_pct = 78;
    test_directed();
    test_table_full();
    test_backpressure();
    test_random_tables(120);

    send_idle_pct = 78;
    recv_idle_pct = 38;
    test_random_tables(120);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_tables(120);

    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("[ip_range_lookup_top] OK");
    end else begin
      $display("[ip_range_lookup_top] ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/ipl_pkg.sv
design/ipl_if.sv
design/ipl_entry_store.sv
design/ipl_group_index.sv
design/ip_range_lookup_top.sv
tb/tb_ip_range_lookup_top.sv
